### sv/csl_pkg.sv
// Package for the C subset lexer: beat types, mode and kind codes, constants.
// Used by every module of the block but csl_ram; depends on nothing.
`default_nettype none
package csl_pkg;
  localparam int TOKEN_CHARS  = 64;
  localparam int SYMBOL_SLOTS = 128;
  localparam int TCW = $clog2(TOKEN_CHARS);
  localparam int SSW = $clog2(SYMBOL_SLOTS);
  localparam int TXT_DEPTH = SYMBOL_SLOTS * TOKEN_CHARS;
  localparam int TXW = $clog2(TXT_DEPTH);
  localparam logic [7:0]  ERROR_CAP = 8'd128;
  localparam logic [15:0] LINE_CAP  = 16'hFFFF;

  localparam logic [2:0] M_IDLE   = 3'd0;
  localparam logic [2:0] M_SLASH  = 3'd1;
  localparam logic [2:0] M_LINEC  = 3'd2;
  localparam logic [2:0] M_BLOCKC = 3'd3;
  localparam logic [2:0] M_NUM    = 3'd4;
  localparam logic [2:0] M_WORD   = 3'd5;
  localparam logic [2:0] M_OPER   = 3'd6;

  localparam logic [2:0] K_NUM     = 3'd0;
  localparam logic [2:0] K_KEY     = 3'd1;
  localparam logic [2:0] K_IDENT   = 3'd2;
  localparam logic [2:0] K_REL     = 3'd3;
  localparam logic [2:0] K_OP      = 3'd4;
  localparam logic [2:0] K_PAREN   = 3'd5;
  localparam logic [2:0] K_INVALID = 3'd6;
  localparam logic [2:0] K_END     = 3'd7;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_input;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]  token_kind;
    logic [15:0] line_number;
    logic [6:0]  token_length;
    logic [2:0]  keyword_index;
    logic [7:0]  symbol_slot;
    logic [7:0]  first_char;
    logic [7:0]  symbol_total;
    logic [7:0]  error_total;
    logic        last_of_run;
  } out_beat_t;

  // Symbol store write request from the copier, csl_symcopy.
  typedef struct packed {
    logic           we;
    logic [TXW-1:0] addr;
    logic [7:0]     data;
  } txt_wr_t;

  typedef struct packed {
    logic           we;
    logic [SSW-1:0] addr;
    logic [15:0]    data;
  } line_wr_t;

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction
  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
  endfunction
  function automatic logic is_opchar(input logic [7:0] c);
    return c == 8'h2b || c == 8'h2d || c == 8'h2a || c == 8'h2f ||
           c == 8'h3c || c == 8'h3e || c == 8'h3d || c == 8'h21;
  endfunction
endpackage
`default_nettype wire

### sv/c_subset_lexer.sv
// Top level of the C subset lexer: scanner, token buffer RAM, symbol stores.
// Depends on csl_pkg, csl_scan, csl_symcopy, csl_ram.
//
//  channel | direction | handshake          | payload
//  in      | in        | in_valid/in_ready  | csl_pkg::in_beat_t
//  out     | out       | out_valid/out_ready| csl_pkg::out_beat_t
//
// One character a cycle unless the output or a copy stalls; a character that
// yields two results holds the input until the second beat leaves the
// two-entry output queue. A stored identifier copies its text into the symbol
// store one character a cycle and holds the input until the copy is done.
// Reset is synchronous; all store contents are undefined until written.
`default_nettype none
module c_subset_lexer (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output      logic               in_ready,
  input  wire csl_pkg::in_beat_t  in_data,
  output      logic               out_valid,
  input  wire logic               out_ready,
  output      csl_pkg::out_beat_t out_data
);
  import csl_pkg::*;

  logic [TCW-1:0] tok_waddr, tok_raddr;
  logic [7:0]     tok_wdata, tok_rdata, txt_rdata, sym_first;
  logic           tok_we, sym_start, copy_busy, go;
  logic [SSW-1:0] sym_slot;
  logic [6:0]     sym_len;
  logic [15:0]    sym_line, line_rdata;
  logic [1:0]     n_res;
  out_beat_t      res0, res1;
  txt_wr_t        txt_wr;
  line_wr_t       line_wr;

  // Two-entry output queue.
  out_beat_t q [2];
  logic [1:0] qn;
  logic       pop;

  assign out_valid = qn != 2'd0;
  assign out_data  = q[0];
  assign pop       = out_valid && out_ready;
  // Accept when both results fit after this cycle's pop and no copy conflicts.
  assign in_ready  = (qn == 2'd0 || (qn == 2'd1 && pop)) && !copy_busy;
  assign go        = in_valid && in_ready;

  // An accepted beat always finds the queue empty after this cycle's pop.
  always_ff @(posedge clk) begin
    logic [1:0] base;
    base = qn - {1'b0, pop};
    if (rst) qn <= '0;
    else qn <= base + (go ? n_res : 2'd0);
    if (go && n_res != 2'd0) begin
      q[0] <= res0;
      q[1] <= res1;
    end else if (pop) q[0] <= q[1];
  end

  csl_scan u_scan (
    .clk, .rst, .in_beat(in_data), .go,
    .tok_waddr, .tok_wdata, .tok_we,
    .sym_start, .sym_slot, .sym_len, .sym_line, .sym_first,
    .n_res, .res0, .res1
  );

  csl_ram #(.WIDTH(8), .DEPTH(TOKEN_CHARS)) u_tok (
    .clk, .we(tok_we && go), .waddr(tok_waddr), .wdata(tok_wdata),
    .raddr(tok_raddr), .rdata(tok_rdata)
  );

  csl_symcopy u_copy (
    .clk, .rst, .start(sym_start && go), .slot(sym_slot), .len(sym_len),
    .line(sym_line), .first(sym_first), .tok_rdata, .tok_raddr, .busy(copy_busy),
    .txt_wr, .line_wr
  );

  csl_ram #(.WIDTH(8), .DEPTH(TXT_DEPTH)) u_txt (
    .clk, .we(txt_wr.we), .waddr(txt_wr.addr), .wdata(txt_wr.data),
    .raddr(txt_wr.addr), .rdata(txt_rdata)
  );

  csl_ram #(.WIDTH(16), .DEPTH(SYMBOL_SLOTS)) u_line (
    .clk, .we(line_wr.we), .waddr(line_wr.addr), .wdata(line_wr.data),
    .raddr(line_wr.addr), .rdata(line_rdata)
  );
endmodule
`default_nettype wire

### sv/csl_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none
module csl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

### sv/csl_symcopy.sv
// Copies a finished identifier from the token buffer into the symbol store.
// Depends on csl_pkg; one character a cycle, holding the top's input while busy.
`default_nettype none
module csl_symcopy (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  input  wire logic [csl_pkg::SSW-1:0]  slot,
  input  wire logic [6:0]               len,
  input  wire logic [15:0]              line,
  input  wire logic [7:0]               first,
  input  wire logic [7:0]               tok_rdata,
  output      logic [csl_pkg::TCW-1:0]  tok_raddr,
  output      logic                     busy,
  output      csl_pkg::txt_wr_t         txt_wr,
  output      csl_pkg::line_wr_t        line_wr
);
  import csl_pkg::*;

  logic           active;
  logic [TCW:0]   idx;
  logic           rd_valid;
  logic [TCW-1:0] rd_idx;
  logic [SSW-1:0] cur_slot;
  logic [6:0]     cur_len;
  logic [7:0]     cur_first;

  assign busy      = active || rd_valid;
  assign tok_raddr = idx[TCW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      active   <= 1'b0;
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= active;
      if (start) begin
        active <= 1'b1;
        idx    <= '0;
      end else if (active) begin
        idx <= idx + 1'b1;
        if (idx == (TCW+1)'(TOKEN_CHARS - 1)) begin
          active <= 1'b0;
        end
      end
    end
    if (start) begin
      cur_slot  <= slot;
      cur_len   <= len;
      cur_first <= first;
    end
    rd_idx <= idx[TCW-1:0];
  end

  // Take the first character from the latched copy: the buffer's entry 0 may
  // already hold the start of the next token. Pad past the length with zeros.
  always_comb begin
    txt_wr.we   = rd_valid;
    txt_wr.addr = {cur_slot, rd_idx};
    if (rd_idx == '0) txt_wr.data = cur_first;
    else txt_wr.data = ({1'b0, rd_idx} < cur_len[TCW:0] || cur_len > 7'(TOKEN_CHARS - 1))
                       ? tok_rdata : 8'h00;
    line_wr.we   = start;
    line_wr.addr = slot;
    line_wr.data = line;
  end
endmodule
`default_nettype wire

### sv/csl_scan.sv
// Per-character scanner: mode machine, keyword match, counters, result beats.
// Depends on csl_pkg.
`default_nettype none
module csl_scan (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire csl_pkg::in_beat_t  in_beat,
  input  wire logic               go,
  output      logic [csl_pkg::TCW-1:0] tok_waddr,
  output      logic [7:0]         tok_wdata,
  output      logic               tok_we,
  output      logic               sym_start,
  output      logic [csl_pkg::SSW-1:0] sym_slot,
  output      logic [6:0]         sym_len,
  output      logic [15:0]        sym_line,
  output      logic [7:0]         sym_first,
  output      logic [1:0]         n_res,
  output      csl_pkg::out_beat_t res0,
  output      csl_pkg::out_beat_t res1
);
  import csl_pkg::*;

  logic [2:0]  mode, mode_next;
  logic [6:0]  count, count_next;
  logic [15:0] line, line_next;
  logic        star, star_next;
  logic [7:0]  syms, syms_next;
  logic [7:0]  errs, errs_next;
  logic [7:0]  first, first_next;
  logic [7:0]  second;
  // Keyword prefix matches, one bit per keyword, built as characters arrive.
  logic [5:0]  kwm, kwm_next;

  logic [7:0]  c;
  assign c = in_beat.char_code;

  localparam logic [2:0] KW_LEN [6] = '{3'd3, 3'd5, 3'd2, 3'd4, 3'd5, 3'd6};
  // Keyword text, right-aligned: the first character sits in the highest used byte.
  localparam logic [47:0] KW_TEXT [6] = '{"int", "float", "if", "else", "while", "return"};

  function automatic logic [7:0] kw_char(input int k, input int i);
    int len;
    len = int'(KW_LEN[k]);
    return (i < len) ? KW_TEXT[k][8*(len-1-i) +: 8] : 8'h00;
  endfunction

  out_beat_t r [2];
  int unsigned n;

  always_comb begin
    logic [2:0] kwi;
    logic       kwhit;
    logic       flush_now;
    logic       do_idle;
    logic       rel;
    mode_next  = mode;
    count_next = count;
    line_next  = line;
    star_next  = star;
    syms_next  = syms;
    errs_next  = errs;
    first_next = first;
    kwm_next   = kwm;
    tok_we     = 1'b0;
    tok_waddr  = count[TCW-1:0];
    tok_wdata  = c;
    sym_start  = 1'b0;
    sym_slot   = syms[SSW-1:0];
    sym_len    = count;
    sym_line   = line;
    sym_first  = first;
    n          = 0;
    r[0]       = '0;
    r[1]       = '0;
    flush_now  = 1'b0;
    do_idle    = 1'b0;
    kwi        = 3'd0;
    kwhit      = 1'b0;
    for (int k = 5; k >= 0; k--) begin
      if (kwm[k] && count == {4'd0, KW_LEN[k]}) begin
        kwhit = 1'b1;
        kwi   = 3'(k);
      end
    end
    rel = count == 7'd2 && second == 8'h3d &&
          (first == 8'h3d || first == 8'h21 || first == 8'h3c || first == 8'h3e);

    if (in_beat.end_of_input) begin
      if (mode == M_SLASH) begin
        mode_next = M_OPER; count_next = 7'd1; first_next = 8'h2f;
        r[0] = '0;
        r[0].token_kind = K_OP; r[0].token_length = 7'd1; r[0].first_char = 8'h2f;
        r[0].line_number = line; r[0].symbol_total = syms; r[0].error_total = errs;
        n = 1;
      end else if (mode == M_NUM || mode == M_WORD || mode == M_OPER) begin
        flush_now = 1'b1;
      end
      star_next = 1'b0;
    end else begin
      unique case (mode)
        M_SLASH: begin
          if (c == 8'h2f) mode_next = M_LINEC;
          else if (c == 8'h2a) begin
            mode_next = M_BLOCKC; star_next = 1'b0;
          end else if (is_opchar(c)) begin
            mode_next = M_OPER; count_next = 7'd2; first_next = 8'h2f;
            tok_we = 1'b1; tok_waddr = TCW'(1);
          end else begin
            // Flush the lone slash operator, then start on c.
            r[0].token_kind = K_OP; r[0].token_length = 7'd1; r[0].first_char = 8'h2f;
            r[0].line_number = line; r[0].symbol_total = syms; r[0].error_total = errs;
            n = 1; do_idle = 1'b1;
          end
        end
        M_OPER: begin
          if (is_opchar(c)) begin
            if (count < 7'(TOKEN_CHARS)) begin
              tok_we = 1'b1; count_next = count + 1'b1;
            end
          end else begin
            flush_now = 1'b1; do_idle = 1'b1;
          end
        end
        M_LINEC: if (c == 8'h0a) do_idle = 1'b1;
        M_BLOCKC: begin
          if (c == 8'h0a && line < LINE_CAP) line_next = line + 1'b1;
          if (star && c == 8'h2f) begin
            mode_next = M_IDLE; star_next = 1'b0;
          end else star_next = (c == 8'h2a);
        end
        M_NUM: begin
          if (is_digit(c) || c == 8'h2e) begin
            if (count < 7'(TOKEN_CHARS)) begin
              tok_we = 1'b1; count_next = count + 1'b1;
            end
          end else begin
            flush_now = 1'b1; do_idle = 1'b1;
          end
        end
        M_WORD: begin
          if (is_alpha(c) || is_digit(c) || c == 8'h5f) begin
            if (count < 7'(TOKEN_CHARS)) begin
              tok_we = 1'b1; count_next = count + 1'b1;
              for (int k = 0; k < 6; k++) begin
                kwm_next[k] = kwm[k] && count < 7'd6 &&
                              kw_char(k, int'(count)) == c;
              end
            end
          end else begin
            flush_now = 1'b1; do_idle = 1'b1;
          end
        end
        default: do_idle = 1'b1;
      endcase
    end

    if (flush_now) begin
      r[0].line_number = line; r[0].token_length = count; r[0].first_char = first;
      r[0].error_total = errs; r[0].symbol_total = syms;
      if (mode == M_NUM) r[0].token_kind = K_NUM;
      else if (mode == M_OPER) r[0].token_kind = rel ? K_REL : K_OP;
      else if (kwhit) begin
        r[0].token_kind = K_KEY; r[0].keyword_index = kwi;
      end else begin
        r[0].token_kind = K_IDENT;
        if ({1'b0, syms} < 9'(SYMBOL_SLOTS)) begin
          r[0].symbol_slot = syms;
          syms_next = syms + 1'b1;
          r[0].symbol_total = syms + 1'b1;
          sym_start = 1'b1;
        end else r[0].symbol_slot = 8'(SYMBOL_SLOTS);
      end
      n = 1;
      mode_next = M_IDLE; count_next = '0;
    end

    if (do_idle) begin
      mode_next = M_IDLE; count_next = '0;
      if (c == 8'h20 || c == 8'h09) begin
      end else if (c == 8'h0a) begin
        if (line < LINE_CAP) line_next = line + 1'b1;
      end else if (c == 8'h2f) mode_next = M_SLASH;
      else if (is_digit(c) || is_alpha(c) || is_opchar(c)) begin
        mode_next = is_digit(c) ? M_NUM : (is_alpha(c) ? M_WORD : M_OPER);
        count_next = 7'd1; first_next = c; tok_we = 1'b1; tok_waddr = '0;
        for (int k = 0; k < 6; k++) kwm_next[k] = kw_char(k, 0) == c;
      end else begin
        r[n] = '0;
        r[n].line_number = line; r[n].token_length = 7'd1; r[n].first_char = c;
        r[n].symbol_total = syms_next;
        if (c == 8'h28 || c == 8'h29) begin
          r[n].token_kind = K_PAREN; r[n].error_total = errs;
        end else begin
          if (errs < ERROR_CAP) errs_next = errs + 1'b1;
          r[n].token_kind = K_INVALID; r[n].error_total = errs_next;
        end
        n = n + 1;
      end
    end

    if (in_beat.end_of_input) begin
      // After a held slash, the flush beat was already built above.
      if (mode != M_SLASH) n = flush_now ? 1 : 0;
      r[n] = '0;
      r[n].token_kind = K_END; r[n].line_number = line;
      r[n].symbol_total = syms_next; r[n].error_total = errs;
      n = n + 1;
      mode_next = M_IDLE; count_next = '0;
    end
    if (n == 2) r[1].last_of_run = 1'b1;
    else r[0].last_of_run = 1'b1;
  end

  assign n_res = 2'(n);
  assign res0  = r[0];
  assign res1  = r[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= M_IDLE;
      count <= '0;
      line <= 16'd1;
      star <= 1'b0;
      syms <= '0;
      errs <= '0;
    end else if (go) begin
      mode <= mode_next;
      count <= count_next;
      line <= line_next;
      star <= star_next;
      syms <= syms_next;
      errs <= errs_next;
    end
    if (go) begin
      first <= first_next;
      kwm   <= kwm_next;
      if (tok_we && tok_waddr == TCW'(1)) second <= c;
    end
  end
endmodule
`default_nettype wire

### sv/csl_checker.sv
// Port-level checker for the C subset lexer, bound to the top level.
// Depends on csl_pkg.
`default_nettype none
module csl_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire csl_pkg::in_beat_t  in_data,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire csl_pkg::out_beat_t out_data
);
  import csl_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output beat changed while stalled");

  a_end_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.token_kind == K_END |-> out_data.last_of_run)
    else $error("end beat not last of run");

  a_line_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.line_number != 16'd0)
    else $error("line number zero");

  a_err_cap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.error_total <= ERROR_CAP)
    else $error("error count beyond cap");
endmodule

bind c_subset_lexer csl_checker u_chk (.*);
`default_nettype wire
